// File: sv/aprp_pkg.sv
`default_nettype none

package aprp_pkg;

    localparam int FRAMES    = 16;
    localparam int PAGE_BITS = 16;
    localparam int AGE_W     = 8;
    localparam int CFG_W     = 5;
    localparam int OUT_IDX_W = 4;

    // Frame index width and a count width that can hold FRAMES itself.
    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = CFG_W'(16);

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } t_state;

    // Search token handed from cell to cell, one cell per cycle.
    typedef struct packed {
        logic                 vld;
        logic                 found;
        logic [IDX_W-1:0]     where_idx;
        logic                 have_best;
        logic [IDX_W-1:0]     best_idx;
        logic [AGE_W-1:0]     best_age;
        logic [PAGE_BITS-1:0] best_page;
    } t_token;

    // Controls that the controller broadcasts to every cell.
    typedef struct packed {
        logic                 age_en;
        logic [PAGE_BITS-1:0] key;
        logic [CNT_W-1:0]     active_n;
        logic                 load_en;
        logic [IDX_W-1:0]     load_idx;
        logic [PAGE_BITS-1:0] load_page;
    } t_bcast;

endpackage

`default_nettype wire

// File: sv/aprp_cell.sv
`default_nettype none

module aprp_cell (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire  [aprp_pkg::IDX_W-1:0]    i_index,
    input  wire  aprp_pkg::t_bcast        i_bcast,
    input  wire  aprp_pkg::t_token        i_tok,
    output aprp_pkg::t_token              o_tok
);
    import aprp_pkg::*;

    logic [PAGE_BITS-1:0] r_page;
    logic                 r_valid;
    logic [AGE_W-1:0]     r_age;
    logic                 r_ref;
    t_token               r_tok;
    t_token               n_tok;

    logic w_active;
    logic w_match;
    logic w_better;
    logic w_load;

    assign w_active = i_tok.vld && (CNT_W'(i_index) < i_bcast.active_n);
    assign w_match  = w_active && r_valid && (r_page == i_bcast.key);
    assign w_load   = i_bcast.load_en && (i_bcast.load_idx == i_index);

    // Smaller counter wins; on equal counters the lower page wins, and a full
    // tie keeps the earlier frame.
    assign w_better = !i_tok.have_best
                   || (r_age < i_tok.best_age)
                   || ((r_age == i_tok.best_age) && (r_page < i_tok.best_page));

    always_comb begin
        n_tok = i_tok;
        if (w_match && !i_tok.found) begin
            n_tok.found     = 1'b1;
            n_tok.where_idx = i_index;
        end
        if (w_active && w_better) begin
            n_tok.have_best = 1'b1;
            n_tok.best_idx  = i_index;
            n_tok.best_age  = r_age;
            n_tok.best_page = r_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_age   <= '0;
            r_ref   <= 1'b0;
            r_tok   <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_age   <= '0;
                r_ref   <= 1'b1;
            end else if (i_bcast.age_en) begin
                r_age <= {r_ref, r_age[AGE_W-1:1]};
                r_ref <= 1'b0;
            end else if (w_match) begin
                r_ref <= 1'b1;
            end
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_page <= i_bcast.load_page;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// File: sv/aprp_ctrl.sv
`default_nettype none

module aprp_ctrl (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire  [31:0]                   i_tick_stamp,
    input  wire  [15:0]                   i_page_number,
    input  wire                           i_cfg_we,
    input  wire  [aprp_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  wire  aprp_pkg::t_token        i_tok_end,
    output aprp_pkg::t_token              o_tok_start,
    output aprp_pkg::t_bcast              o_bcast,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic [aprp_pkg::OUT_IDX_W-1:0] o_frame_index
);
    import aprp_pkg::*;

    t_state               r_state;
    t_state               n_state;
    logic [CFG_W-1:0]     r_frames_in_use;
    logic [31:0]          r_last_tick;
    logic [CNT_W-1:0]     r_fill;
    logic [PAGE_BITS-1:0] r_key;
    t_token               r_inject;
    logic                 r_out_vld;
    logic                 r_out_hit;
    logic [IDX_W-1:0]     r_out_idx;

    logic                 w_accept;
    logic [CMP_W-1:0]     w_cfg_ext;
    logic [CNT_W-1:0]     w_n;
    logic                 w_done;
    logic                 w_load;
    logic [IDX_W-1:0]     w_where;

    assign w_accept  = start && !busy;
    assign w_cfg_ext = CMP_W'(r_frames_in_use);

    // A count of zero acts as one; a count above the frame total is capped.
    always_comb begin
        priority if (w_cfg_ext == '0) begin
            w_n = CNT_W'(1);
        end else if (w_cfg_ext > CMP_W'(FRAMES)) begin
            w_n = CNT_W'(FRAMES);
        end else begin
            w_n = CNT_W'(w_cfg_ext);
        end
    end

    assign w_done = (r_state == ST_SWEEP) && i_tok_end.vld;

    always_comb begin
        w_load  = 1'b0;
        w_where = i_tok_end.best_idx;
        priority if (i_tok_end.found) begin
            w_where = i_tok_end.where_idx;
        end else if (r_fill < w_n) begin
            w_load  = w_done;
            w_where = r_fill[IDX_W-1:0];
        end else begin
            w_load  = w_done;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_accept) n_state = ST_SWEEP;
            ST_SWEEP: if (w_done)   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        unique case (r_state)
            ST_IDLE:  busy = 1'b0;
            ST_SWEEP: busy = 1'b1;
            default:  busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_frames_in_use <= FRAMES_IN_USE_RST;
            r_last_tick     <= '0;
            r_fill          <= '0;
            r_inject        <= '0;
            r_out_vld       <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= w_done;
            if (i_cfg_we) begin
                r_frames_in_use <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_last_tick <= i_tick_stamp;
            end
            if (w_load && !i_tok_end.found && (r_fill < w_n)) begin
                r_fill <= r_fill + CNT_W'(1);
            end
            // The other token fields stay at their reset value of zero.
            r_inject.vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= PAGE_BITS'(i_page_number);
        end
        if (w_done) begin
            r_out_hit <= i_tok_end.found;
            r_out_idx <= w_where;
        end
    end

    // Aging happens at the accept edge when the tick stamp has changed, before the search token enters.
    assign o_bcast.age_en    = w_accept && (i_tick_stamp != r_last_tick);
    assign o_bcast.key       = r_key;
    assign o_bcast.active_n  = w_n;
    assign o_bcast.load_en   = w_load;
    assign o_bcast.load_idx  = w_where;
    assign o_bcast.load_page = r_key;

    assign o_tok_start   = r_inject;
    assign o_valid       = r_out_vld;
    assign o_hit         = r_out_hit;
    assign o_frame_index = OUT_IDX_W'(r_out_idx);

endmodule

`default_nettype wire

// File: sv/aging_page_replacement.sv
// The result strobe follows the accepting edge once the search token, crossing one
// cell a cycle, has passed every cell and then the output register.
// One transaction runs at a time; busy is high while it runs.
// Each result stands for exactly one cycle; the receiver cannot stall it.
// Reset (synchronous, active low) clears all frames to invalid, counters and
// reference bits to zero, the last tick to zero and frames_in_use to 16.
`default_nettype none

module aging_page_replacement (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire  [31:0]                   i_tick_stamp,
    input  wire  [15:0]                   i_page_number,
    input  wire                           i_cfg_we,
    input  wire  [aprp_pkg::CFG_W-1:0]    i_cfg_wdata,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic [aprp_pkg::OUT_IDX_W-1:0] o_frame_index
);
    import aprp_pkg::*;

    t_token w_tok [FRAMES+1];
    t_bcast w_bcast;

    aprp_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_tick_stamp  (i_tick_stamp),
        .i_page_number (i_page_number),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_tok_end     (w_tok[FRAMES]),
        .o_tok_start   (w_tok[0]),
        .o_bcast       (w_bcast),
        .o_valid       (o_valid),
        .o_hit         (o_hit),
        .o_frame_index (o_frame_index)
    );

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        aprp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(g)),
            .i_bcast (w_bcast),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

endmodule

`default_nettype wire

// File: bench/aging_page_replacement_tb.sv
`default_nettype none

module aging_page_replacement_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aprp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP   = 40;

    typedef struct packed {
        logic                 hit;
        logic [OUT_IDX_W-1:0] frame;
    } t_ref_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [31:0]          i_tick_stamp = '0;
    logic [15:0]          i_page_number = '0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 o_valid;
    logic                 o_hit;
    logic [OUT_IDX_W-1:0] o_frame_index;

    // Shadow of the replacement state, updated once per accepted transaction.
    logic [PAGE_BITS-1:0] shadow_page [FRAMES];
    bit                   shadow_valid [FRAMES];
    logic [AGE_W-1:0]     shadow_age [FRAMES];
    bit                   shadow_ref [FRAMES];
    int                   shadow_fill = 0;
    logic [31:0]          shadow_tick = '0;
    logic [CFG_W-1:0]     frames_cfg = FRAMES_IN_USE_RST;

    t_ref_result results_due[$];
    t_ref_result want;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    logic [31:0] cur_tick = '0;
    bit          steady = 1'b0;

    aging_page_replacement i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_tick_stamp  (i_tick_stamp),
        .i_page_number (i_page_number),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_valid       (o_valid),
        .o_hit         (o_hit),
        .o_frame_index (o_frame_index)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $time, results_due.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic int active_frames();
        if (frames_cfg == 0) return 1;
        if (frames_cfg > FRAMES) return FRAMES;
        return int'(frames_cfg);
    endfunction

    function automatic t_ref_result predict_reference(logic [31:0] tick,
                                                      logic [PAGE_BITS-1:0] page);
        int          n;
        int          victim;
        bit          found;
        t_ref_result r;
        n = active_frames();
        found = 1'b0;
        r = '0;
        // Any change of tick ages every frame exactly once, active or not.
        if (tick != shadow_tick) begin
            shadow_tick = tick;
            for (int i = 0; i < FRAMES; i++) begin
                shadow_age[i] = {shadow_ref[i], shadow_age[i][AGE_W-1:1]};
                shadow_ref[i] = 1'b0;
            end
        end
        for (int i = 0; i < n; i++) begin
            if (shadow_valid[i] && shadow_page[i] == page) begin
                shadow_ref[i] = 1'b1;
                if (!found) begin
                    found = 1'b1;
                    r.frame = OUT_IDX_W'(i);
                end
            end
        end
        if (!found) begin
            if (shadow_fill < n) begin
                victim = shadow_fill;
                shadow_fill++;
            end else begin
                victim = 0;
                for (int i = 1; i < n; i++) begin
                    if (shadow_age[i] < shadow_age[victim] ||
                        (shadow_age[i] == shadow_age[victim] &&
                         shadow_page[i] < shadow_page[victim]))
                        victim = i;
                end
            end
            shadow_page[victim]  = page;
            shadow_valid[victim] = 1'b1;
            shadow_age[victim]   = '0;
            shadow_ref[victim]   = 1'b1;
            r.frame = OUT_IDX_W'(victim);
        end
        r.hit = found;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= PRINT_CAP)
                    $display("%0t result with none expected: hit=%0d frame=%0d",
                             $time, o_hit, o_frame_index);
            end else begin
                want = results_due.pop_front();
                if (o_hit !== want.hit) begin
                    mismatches++;
                    if (mismatches <= PRINT_CAP)
                        $display("%0t hit mismatch: expected %0d actual %0d",
                                 $time, want.hit, o_hit);
                end
                if (o_frame_index !== want.frame) begin
                    mismatches++;
                    if (mismatches <= PRINT_CAP)
                        $display("%0t frame_index mismatch: expected %0d actual %0d",
                                 $time, want.frame, o_frame_index);
                end
            end
        end
    end

    // Called at a rising edge; returns at the edge that accepted the transaction,
    // with start still high so the next call can follow back to back.
    task automatic send_reference(input logic [31:0] tick, input logic [15:0] page);
        if (!steady && $urandom_range(0, 99) < 10) begin
            start         <= 1'b0;
            i_tick_stamp  <= $urandom;
            i_page_number <= 16'($urandom);
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_tick_stamp  <= tick;
        i_page_number <= page;
        do begin
            @(posedge i_clk);
        end while (busy);
        cur_tick = tick;
        results_due.push_back(predict_reference(tick, page));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_frames_in_use(input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        frames_cfg = value;
    endtask

    function automatic logic [31:0] next_tick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return cur_tick;
        if (r < 85) return cur_tick + 32'd1;
        if (r < 95) return $urandom;
        return (r < 97) ? 32'h0 : 32'hFFFF_FFFF;
    endfunction

    function automatic logic [15:0] pick_page(logic [15:0] base, int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return base ^ 16'($urandom_range(0, span));
        if (r < 90) return 16'($urandom);
        return (r < 95) ? 16'h0000 : 16'hFFFF;
    endfunction

    // From reset: the first tick-0 reference must not age, then fills and hits.
    task automatic test_reset_fill_and_hit();
        send_reference(32'h0, 16'h0000);
        send_reference(32'h0, 16'hFFFF);
        send_reference(32'h1, 16'h0000);
        send_reference(32'h1, 16'h0000);
        send_reference(32'h2, 16'hA5A5);
        drain_results();
    endtask

    // Zero acts as one frame; a later larger count exposes duplicate residents.
    task automatic test_frame_count_limits();
        write_frames_in_use(CFG_W'(0));
        send_reference(32'h2, 16'h1234);
        send_reference(32'h2, 16'h1234);
        send_reference(32'hFFFF_FFFF, 16'hFFFF);
        drain_results();
        write_frames_in_use(CFG_W'(2));
        send_reference(32'hFFFF_FFFF, 16'hFFFF);
        send_reference(32'h0, 16'h5555);
        send_reference(32'h0, 16'h0000);
        drain_results();
        write_frames_in_use(CFG_W'(31));
        send_reference(32'h3, 16'hFFFF);
        send_reference(32'h3, 16'h7777);
        drain_results();
        write_frames_in_use(CFG_W'(17));
        send_reference(32'h4, 16'h1234);
        drain_results();
    endtask

    // Loads within one tick all carry age zero, so victims fall to page order.
    task automatic test_eviction_ties();
        write_frames_in_use(CFG_W'(4));
        send_reference(32'h10, 16'h0300);
        send_reference(32'h10, 16'h0100);
        send_reference(32'h10, 16'h0200);
        send_reference(32'h10, 16'h0400);
        send_reference(32'h10, 16'h0050);
        send_reference(32'h11, 16'h0100);
        send_reference(32'h12, 16'h0060);
        drain_results();
    endtask

    task automatic test_random_references();
        logic [CFG_W-1:0] plan [12] = '{16, 1, 0, 31, 2, 17, 15, 8, 3, 16, 5, 12};
        logic [15:0]      base;
        int               span;
        for (int p = 0; p < 12; p++) begin
            if (p % 3 == 0) base = 16'($urandom);
            write_frames_in_use((p % 4 == 3) ? CFG_W'($urandom_range(0, 31)) : plan[p]);
            steady = (p == 6);
            span = active_frames() + $urandom_range(0, 6);
            for (int k = 0; k < 90; k++)
                send_reference(next_tick(), pick_page(base, span));
            drain_results();
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_fill_and_hit();
        test_frame_count_limits();
        test_eviction_ties();
        test_random_references();
        repeat (FRAMES + 2) @(posedge i_clk);
        if (mismatches == 0 && results_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
sv/aprp_pkg.sv
sv/aprp_cell.sv
sv/aprp_ctrl.sv
sv/aging_page_replacement.sv
bench/aging_page_replacement_tb.sv
